[rtl/core/double_buffered_line_receiver_assert.svh]
// Assertion helpers shared by the receiver RTL.
`ifndef DOUBLE_BUFFERED_LINE_RECEIVER_ASSERT_SVH
`define DOUBLE_BUFFERED_LINE_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DBLR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DBLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/dblr_pkg.sv]
package dblr_pkg;

   // Field widths of the item and result channels.
   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 16;

   // Line banks: two banks of LINE_SIZE bytes each.
   localparam int LINE_SIZE   = 128;
   localparam int STORE_DEPTH = 2 * LINE_SIZE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [BYTE_W-1:0] END_CHAR_RESET = BYTE_W'(13);

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_RECEIVE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TAKE    = 2'd2;

   // Status carried from the accept stage to the result register.
   typedef struct packed {
      logic               line_ready;
      logic [POS_W-1:0]   line_length;
      logic               taken;
      logic               read_hit;
      logic [COUNT_W-1:0] byte_overflows;
      logic [COUNT_W-1:0] line_overflows;
   } stat_type;

endpackage

[rtl/core/dblr_if.sv]
interface dblr_req_if;
   logic                               valid;
   logic                               ready;
   logic [dblr_pkg::ACTION_W-1:0]      action;
   logic [dblr_pkg::BYTE_W-1:0]        rx_byte;
   logic [dblr_pkg::POS_W-1:0]         read_pos;

   modport source (output valid, action, rx_byte, read_pos, input ready);
   modport sink   (input valid, action, rx_byte, read_pos, output ready);
endinterface

interface dblr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               line_ready;
   logic [dblr_pkg::POS_W-1:0]         line_length;
   logic                               taken;
   logic [dblr_pkg::BYTE_W-1:0]        read_data;
   logic [dblr_pkg::COUNT_W-1:0]       byte_overflows;
   logic [dblr_pkg::COUNT_W-1:0]       line_overflows;

   modport source (output valid, line_ready, line_length, taken, read_data,
                   byte_overflows, line_overflows, input ready);
   modport sink   (input valid, line_ready, line_length, taken, read_data,
                   byte_overflows, line_overflows, output ready);
endinterface

interface dblr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [dblr_pkg::BYTE_W-1:0]        end_char;

   modport source (output valid, end_char, input ready);
   modport sink   (input valid, end_char, output ready);
endinterface

[rtl/core/dblr_ram.sv]
module dblr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      // Hold read data until the next read.
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/double_buffered_line_receiver.sv]
// Path: an item transfer loads the accept stage (s1), then the result register;
//   rsp valid rises when the item moves from s1 into the result register.
// Throughput: one item per cycle while results drain; the single store port serves either the
//   byte write of a receive or the byte read of a read action.
// Reset: synchronous, active high; clears bank/index/flag/counters and sets
//   end_char to 13. The line store is not cleared and needs no clearing pass.
module double_buffered_line_receiver (
   input  logic        clock,
   input  logic        reset,
   dblr_req_if.sink    req_if,
   dblr_rsp_if.source  rsp_if,
   dblr_csr_if.sink    csr_if
);
   import dblr_pkg::*;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + COUNT_W'(1);
   endfunction

   // ---------------------------------------------------------------
   // Architectural state
   // ---------------------------------------------------------------
   logic [BYTE_W-1:0]  end_char_ff;
   logic [POS_W-1:0]   write_index_ff, write_index_in;
   logic               fill_bank_ff,   fill_bank_in;
   logic               ready_flag_ff,  ready_flag_in;
   logic [POS_W-1:0]   ready_len_ff,   ready_len_in;
   logic               ready_bank_ff,  ready_bank_in;
   logic [COUNT_W-1:0] byte_ovf_ff,    byte_ovf_in;
   logic [COUNT_W-1:0] line_ovf_ff,    line_ovf_in;

   // Pipeline: accept stage (s1) and result register.
   logic     s1_valid_ff, s1_valid_in;
   stat_type s1_stat_ff,  s1_stat_in;
   logic     rsp_valid_ff;
   stat_type rsp_stat_ff;
   logic [BYTE_W-1:0] rsp_data_ff;

   logic              req_accept;
   logic              s1_advance;
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_addr;
   logic [BYTE_W-1:0] ram_rdata;
   logic [POS_W:0]    index_inc;
   logic              taken_now;
   logic              read_hit_now;
   logic [POS_W-1:0]  take_len;

   // Configuration: always ready; the user must write it only while idle (not enforced here).
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_char_ff <= END_CHAR_RESET;
      end else if (csr_if.valid) begin
         end_char_ff <= csr_if.end_char;
      end
   end

   // Advance s1 whenever the result register is free or being drained;
   // take a new item only if s1 will be empty. A stalled s1 thus never sees
   // a new RAM read, so the RAM read data stays put under it.
   assign s1_advance   = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_accept   = req_if.valid && req_if.ready;

   assign index_inc = {1'b0, write_index_ff} + (POS_W+1)'(1);

   // ---------------------------------------------------------------
   // Next state for one item
   // ---------------------------------------------------------------
   always_comb begin
      write_index_in = write_index_ff;
      fill_bank_in   = fill_bank_ff;
      ready_flag_in  = ready_flag_ff;
      ready_len_in   = ready_len_ff;
      ready_bank_in  = ready_bank_ff;
      byte_ovf_in    = byte_ovf_ff;
      line_ovf_in    = line_ovf_ff;
      taken_now      = 1'b0;
      read_hit_now   = 1'b0;
      take_len       = '0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_addr       = {fill_bank_ff, write_index_ff};

      case (req_if.action)
         ACT_RECEIVE: begin
            // Store the byte first, then end the line, or wrap or advance the index.
            ram_we = req_accept;
            if (req_if.rx_byte == end_char_ff) begin
               if (!ready_flag_ff) begin
                  ready_flag_in = 1'b1;
                  ready_len_in  = write_index_ff;
                  ready_bank_in = fill_bank_ff;
               end else begin
                  line_ovf_in = sat_inc(line_ovf_ff);
               end
               fill_bank_in   = ~fill_bank_ff;
               write_index_in = '0;
            end else if (index_inc == (POS_W+1)'(LINE_SIZE)) begin
               // Overlong line: wrap the index and count it.
               byte_ovf_in    = sat_inc(byte_ovf_ff);
               write_index_in = '0;
            end else begin
               write_index_in = index_inc[POS_W-1:0];
            end
         end
         ACT_READ: begin
            ram_re       = req_accept;
            ram_addr     = {ready_bank_ff, req_if.read_pos};
            read_hit_now = ready_flag_ff && (req_if.read_pos < ready_len_ff);
         end
         ACT_TAKE: begin
            if (ready_flag_ff) begin
               ready_flag_in = 1'b0;
               taken_now     = 1'b1;
               take_len      = ready_len_ff;
            end
         end
         default: begin
            // Unused action: no state change, status only.
         end
      endcase
   end

   // Result status for the accepted item.
   always_comb begin
      s1_stat_in.line_ready     = ready_flag_in;
      s1_stat_in.line_length    = (req_if.action == ACT_TAKE) ? take_len :
                                  (ready_flag_in ? ready_len_in : '0);
      s1_stat_in.taken          = taken_now;
      s1_stat_in.read_hit       = read_hit_now;
      s1_stat_in.byte_overflows = byte_ovf_in;
      s1_stat_in.line_overflows = line_ovf_in;
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Commit state on each item transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         fill_bank_ff   <= 1'b0;
         ready_flag_ff  <= 1'b0;
         ready_len_ff   <= '0;
         ready_bank_ff  <= 1'b0;
         byte_ovf_ff    <= '0;
         line_ovf_ff    <= '0;
      end else if (req_accept) begin
         write_index_ff <= write_index_in;
         fill_bank_ff   <= fill_bank_in;
         ready_flag_ff  <= ready_flag_in;
         ready_len_ff   <= ready_len_in;
         ready_bank_ff  <= ready_bank_in;
         byte_ovf_ff    <= byte_ovf_in;
         line_ovf_ff    <= line_ovf_in;
      end
   end

   // Line store: both banks in one RAM, bank bit on top of the address.
   dblr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (req_if.rx_byte),
      .rdata (ram_rdata)
   );

   // Accept stage and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_stat_ff <= s1_stat_in;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_stat_ff <= s1_stat_ff;
         // Out-of-range reads and non-read actions give zero.
         rsp_data_ff <= s1_stat_ff.read_hit ? ram_rdata : '0;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.line_ready     = rsp_stat_ff.line_ready;
   assign rsp_if.line_length    = rsp_stat_ff.line_length;
   assign rsp_if.taken          = rsp_stat_ff.taken;
   assign rsp_if.read_data      = rsp_data_ff;
   assign rsp_if.byte_overflows = rsp_stat_ff.byte_overflows;
   assign rsp_if.line_overflows = rsp_stat_ff.line_overflows;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`include "double_buffered_line_receiver_assert.svh"

   // A held s1 stage must block new transfers, or its RAM data would move.
   `DBLR_ASSERT_NOW(a_stall_blocks, clock, reset, s1_valid_ff && !s1_advance,
      !req_accept, "item taken while s1 stalled")
   // Overflow counters saturate and never go down; the byte counter is checked here.
   `DBLR_ASSERT_NEXT(a_byte_ovf_mono, clock, reset, 1'b1,
      byte_ovf_ff >= $past(byte_ovf_ff), "byte overflow count fell")
   // A line is published only by a receive transfer.
   `DBLR_ASSERT_NOW(a_ready_source, clock, reset, $rose(ready_flag_ff),
      $past(req_accept) && ($past(req_if.action) == ACT_RECEIVE),
      "line published without a receive")
   // A take result never carries read data.
   `DBLR_ASSERT_NOW(a_take_no_data, clock, reset, rsp_valid_ff && rsp_stat_ff.taken,
      rsp_data_ff == '0, "take result with read data")

endmodule
